>>> design/mcsg_pkg.sv
// Shared types and codes for the midpoint circle span generator.
// No dependencies; the step and span modules use it by scoped names.
`default_nettype none

package mcsg_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef struct packed {
        logic valid;
        logic done;
    } t_job_ctrl;

endpackage

`default_nettype wire

>>> design/midpoint_circle_span_generator.sv
// Filled-circle span generator: top level joining the octant stepper and span serializer.
// Depends on mcsg_pkg, mcsg_step and mcsg_span.
// The first span of an item passes through the serializer's point registers, then its output registers.
// The four spans of an item share one output port; a new item is taken as the fourth span is loaded.
// A step with no circle in progress is accepted and yields no span.
// Reset (synchronous, active low) clears the circle state and empties the output.
`default_nettype none

module midpoint_circle_span_generator #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // center_x, center_y, radius, zero fill
    input  wire logic [((3*COORD_BITS-1+7)/8)*8-1:0] i_s_axis_tdata,
    // op
    input  wire logic                     i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  wire logic                     i_m_axis_tready,
    // column, row_top, row_bottom, zero fill
    output logic [((3*(COORD_BITS+2)+7)/8)*8-1:0] o_m_axis_tdata,
    // last_of_step
    output logic                          o_m_axis_tlast,
    // circle_done
    output logic                          o_m_axis_tuser
);

    localparam int IN_W  = ((3*COORD_BITS-1+7)/8)*8;
    localparam int OUT_W = ((3*(COORD_BITS+2)+7)/8)*8;
    localparam int O_W   = COORD_BITS + 2;

    mcsg_pkg::t_job_ctrl          w_job;
    logic [COORD_BITS-1:0]        w_cx;
    logic [COORD_BITS-1:0]        w_cy;
    logic [COORD_BITS-2:0]        w_x;
    logic [COORD_BITS-2:0]        w_y;
    logic                         w_ready;
    logic                         w_accept;
    logic signed [O_W-1:0]        w_column;
    logic signed [O_W-1:0]        w_row_top;
    logic signed [O_W-1:0]        w_row_bottom;

    assign w_accept        = i_s_axis_tvalid && w_ready;
    assign o_s_axis_tready = w_ready;

    mcsg_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_op       (i_s_axis_tuser),
        .i_center_x (i_s_axis_tdata[COORD_BITS-1:0]),
        .i_center_y (i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_radius   (i_s_axis_tdata[3*COORD_BITS-2:2*COORD_BITS]),
        .o_job      (w_job),
        .o_cx       (w_cx),
        .o_cy       (w_cy),
        .o_x        (w_x),
        .o_y        (w_y)
    );

    mcsg_span #(
        .COORD_BITS (COORD_BITS)
    ) u_span (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (w_job),
        .i_cx         (w_cx),
        .i_cy         (w_cy),
        .i_x          (w_x),
        .i_y          (w_y),
        .o_ready      (w_ready),
        .o_valid      (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_column     (w_column),
        .o_row_top    (w_row_top),
        .o_row_bottom (w_row_bottom),
        .o_last       (o_m_axis_tlast),
        .o_done       (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = OUT_W'({w_row_bottom, w_row_top, w_column});

    logic w_unused_in;
    assign w_unused_in = ^{1'b0, i_s_axis_tdata[IN_W-1:3*COORD_BITS-1]};

endmodule

`default_nettype wire

>>> design/mcsg_step.sv
// Octant stepper: holds the circle state and applies one start or step item per cycle while i_accept is high.
// Depends on mcsg_pkg for the operation codes and the job control struct.
`default_nettype none

module mcsg_step #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic                  i_op,
    input  wire logic [COORD_BITS-1:0] i_center_x,
    input  wire logic [COORD_BITS-1:0] i_center_y,
    input  wire logic [COORD_BITS-2:0] i_radius,
    output mcsg_pkg::t_job_ctrl        o_job,
    output logic      [COORD_BITS-1:0] o_cx,
    output logic      [COORD_BITS-1:0] o_cy,
    output logic      [COORD_BITS-2:0] o_x,
    output logic      [COORD_BITS-2:0] o_y
);

    localparam int X_W = COORD_BITS - 1;
    localparam int E_W = COORD_BITS + 1;
    localparam int D_W = COORD_BITS + 2;

    logic [COORD_BITS-1:0] r_cx, n_cx;
    logic [COORD_BITS-1:0] r_cy, n_cy;
    logic [X_W-1:0]        r_x, n_x;
    logic [X_W-1:0]        r_y, n_y;
    logic signed [D_W-1:0] r_dec, n_dec;
    logic [E_W-1:0]        r_east, n_east;
    logic signed [D_W-1:0] r_se, n_se;
    logic                  r_active, n_active;
    logic                  w_produce;
    logic                  w_done;

    always_comb begin
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_x       = r_x;
        n_y       = r_y;
        n_dec     = r_dec;
        n_east    = r_east;
        n_se      = r_se;
        w_produce = 1'b0;
        if (i_accept) begin
            if (i_op == mcsg_pkg::OP_START) begin
                n_cx      = i_center_x;
                n_cy      = i_center_y;
                n_x       = '0;
                n_y       = i_radius;
                n_dec     = D_W'(1) - D_W'(i_radius);
                n_east    = E_W'(3);
                n_se      = D_W'(5) - D_W'({i_radius, 1'b0});
                w_produce = 1'b1;
            end else if (r_active && (r_x < r_y)) begin
                n_x = r_x + X_W'(1);
                if (r_dec < 0) begin
                    n_dec = r_dec + $signed({1'b0, r_east});
                    n_se  = r_se + D_W'(2);
                end else begin
                    n_dec = r_dec + r_se;
                    n_se  = r_se + D_W'(4);
                    n_y   = r_y - X_W'(1);
                end
                n_east    = r_east + E_W'(2);
                w_produce = 1'b1;
            end
        end
        w_done = (n_x >= n_y);
        if (i_accept) begin
            n_active = w_produce & ~w_done;
        end else begin
            n_active = r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_dec    <= '0;
            r_east   <= '0;
            r_se     <= '0;
            r_active <= 1'b0;
        end else begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_x      <= n_x;
            r_y      <= n_y;
            r_dec    <= n_dec;
            r_east   <= n_east;
            r_se     <= n_se;
            r_active <= n_active;
        end
    end

    assign o_job.valid = w_produce;
    assign o_job.done  = w_done;
    assign o_cx        = n_cx;
    assign o_cy        = n_cy;
    assign o_x         = n_x;
    assign o_y         = n_y;

endmodule

`default_nettype wire

>>> design/mcsg_span.sv
// Span serializer: holds one octant point and emits its four vertical spans in turn.
// Depends on mcsg_pkg for the job control struct.
`default_nettype none

module mcsg_span #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire mcsg_pkg::t_job_ctrl          i_job,
    input  wire logic        [COORD_BITS-1:0] i_cx,
    input  wire logic        [COORD_BITS-1:0] i_cy,
    input  wire logic        [COORD_BITS-2:0] i_x,
    input  wire logic        [COORD_BITS-2:0] i_y,
    output logic                              o_ready,
    output logic                              o_valid,
    input  wire logic                         i_out_ready,
    output logic signed      [COORD_BITS+1:0] o_column,
    output logic signed      [COORD_BITS+1:0] o_row_top,
    output logic signed      [COORD_BITS+1:0] o_row_bottom,
    output logic                              o_last,
    output logic                              o_done
);

    localparam int X_W = COORD_BITS - 1;
    localparam int O_W = COORD_BITS + 2;

    logic                  r_busy;
    logic [1:0]            r_idx;
    logic [COORD_BITS-1:0] r_cx;
    logic [COORD_BITS-1:0] r_cy;
    logic [X_W-1:0]        r_x;
    logic [X_W-1:0]        r_y;
    logic                  r_done;
    logic                  r_valid;
    logic signed [O_W-1:0] r_col;
    logic signed [O_W-1:0] r_top;
    logic signed [O_W-1:0] r_bot;
    logic                  r_last;
    logic                  r_done_o;
    logic                  w_load;
    logic                  w_finish;
    logic signed [O_W-1:0] w_cx;
    logic signed [O_W-1:0] w_cy;
    logic signed [O_W-1:0] w_a;
    logic signed [O_W-1:0] w_b;

    assign w_load   = r_busy && (!r_valid || i_out_ready);
    assign w_finish = w_load && (r_idx == 2'd3);
    assign o_ready  = !r_busy || w_finish;

    assign w_cx = $signed({2'b00, r_cx});
    assign w_cy = $signed({2'b00, r_cy});
    assign w_a  = $signed({3'b000, (r_idx[1] ? r_y : r_x)});
    assign w_b  = $signed({3'b000, (r_idx[1] ? r_x : r_y)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (o_ready && i_job.valid) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (w_finish) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else if (w_load) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_job.valid) begin
            r_cx   <= i_cx;
            r_cy   <= i_cy;
            r_x    <= i_x;
            r_y    <= i_y;
            r_done <= i_job.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_col    <= r_idx[0] ? (w_cx - w_a) : (w_cx + w_a);
            r_top    <= w_cy - w_b;
            r_bot    <= w_cy + w_b;
            r_last   <= (r_idx == 2'd3);
            r_done_o <= r_done;
        end
    end

    assign o_valid      = r_valid;
    assign o_column     = r_col;
    assign o_row_top    = r_top;
    assign o_row_bottom = r_bot;
    assign o_last       = r_last;
    assign o_done       = r_done_o;

    a_idle_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_idx == 2'd0))
        else $error("span index nonzero while idle");

    a_job_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_job.valid) |=> (r_busy && (r_idx == 2'd0)))
        else $error("job accepted but serializer not started");

    a_fourth_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> (r_valid && r_last))
        else $error("fourth span not marked last");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_idx != 2'd3)) |=> (r_valid && !r_last))
        else $error("early span marked last");

endmodule

`default_nettype wire

>>> tb/tb_midpoint_circle_span_generator.sv
// Self-checking testbench for the midpoint circle span generator: drives start and step items
// and checks every span against a cycle-free model of the octant walk kept in a scoreboard.
// Depends on mcsg_pkg and midpoint_circle_span_generator.
`default_nettype none

module tb_midpoint_circle_span_generator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB           = 12;
    localparam int OB           = CB + 2;
    localparam int IN_W         = ((3*CB-1+7)/8)*8;
    localparam int OUT_W        = ((3*OB+7)/8)*8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TARGET_ITEMS = 370;

    typedef struct packed {
        logic signed [OB-1:0] column;
        logic signed [OB-1:0] row_top;
        logic signed [OB-1:0] row_bottom;
        logic                 last_of_step;
        logic                 circle_done;
    } t_span;

    class t_span_board;
        logic [CB-1:0]        centre_col;
        logic [CB-1:0]        centre_row;
        logic [CB-2:0]        oct_x;
        logic [CB-2:0]        oct_y;
        logic signed [OB-1:0] decision;
        logic signed [OB-2:0] east_delta;
        logic signed [OB-1:0] southeast_delta;
        logic                 active;
        t_span                spans_due[$];
        int                   errors;

        function new();
            centre_col      = '0;
            centre_row      = '0;
            oct_x           = '0;
            oct_y           = '0;
            decision        = '0;
            east_delta      = '0;
            southeast_delta = '0;
            active          = 1'b0;
            errors          = 0;
        endfunction

        function void push_octant();
            int    x;
            int    y;
            int    cc;
            int    cr;
            logic  done;
            t_span s;
            x    = int'(oct_x);
            y    = int'(oct_y);
            cc   = int'(centre_col);
            cr   = int'(centre_row);
            done = (oct_x >= oct_y);
            s.circle_done  = done;
            s.last_of_step = 1'b0;
            s.column       = OB'(cc + x);
            s.row_top      = OB'(cr - y);
            s.row_bottom   = OB'(cr + y);
            spans_due      = {spans_due, s};
            s.column       = OB'(cc - x);
            spans_due      = {spans_due, s};
            s.column       = OB'(cc + y);
            s.row_top      = OB'(cr - x);
            s.row_bottom   = OB'(cr + x);
            spans_due      = {spans_due, s};
            s.column       = OB'(cc - y);
            s.last_of_step = 1'b1;
            spans_due      = {spans_due, s};
            active = !done;
        endfunction

        // Returns the number of spans the item is expected to produce.
        function int note_input(logic op, logic [CB-1:0] cx, logic [CB-1:0] cy,
                                logic [CB-2:0] r);
            if (op == mcsg_pkg::OP_START) begin
                centre_col      = cx;
                centre_row      = cy;
                oct_x           = '0;
                oct_y           = r;
                decision        = OB'(1 - int'(r));
                east_delta      = (OB-1)'(3);
                southeast_delta = OB'(5 - 2*int'(r));
                push_octant();
                return 4;
            end
            if (!active || oct_x >= oct_y) begin
                active = 1'b0;
                return 0;
            end
            oct_x = oct_x + 1'b1;
            if (decision < 0) begin
                decision        = decision + east_delta;
                southeast_delta = southeast_delta + OB'(2);
            end else begin
                decision        = decision + southeast_delta;
                southeast_delta = southeast_delta + OB'(4);
                oct_y           = oct_y - 1'b1;
            end
            east_delta = east_delta + (OB-1)'(2);
            push_octant();
            return 4;
        endfunction

        function void check_span(logic [OUT_W-1:0] data, logic last, logic done);
            t_span got;
            t_span want;
            got.column       = data[OB-1:0];
            got.row_top      = data[2*OB-1:OB];
            got.row_bottom   = data[3*OB-1:2*OB];
            got.last_of_step = last;
            got.circle_done  = done;
            if (spans_due.size() == 0) begin
                $error("unexpected span: column %0d rows %0d..%0d", got.column,
                       got.row_top, got.row_bottom);
                errors++;
                return;
            end
            want = spans_due.pop_front();
            if (got.column !== want.column) begin
                $error("column: expected %0d, actual %0d", want.column, got.column);
                errors++;
            end
            if (got.row_top !== want.row_top) begin
                $error("row_top: expected %0d, actual %0d", want.row_top, got.row_top);
                errors++;
            end
            if (got.row_bottom !== want.row_bottom) begin
                $error("row_bottom: expected %0d, actual %0d", want.row_bottom,
                       got.row_bottom);
                errors++;
            end
            if (got.last_of_step !== want.last_of_step) begin
                $error("last_of_step: expected %0b, actual %0b", want.last_of_step,
                       got.last_of_step);
                errors++;
            end
            if (got.circle_done !== want.circle_done) begin
                $error("circle_done: expected %0b, actual %0b", want.circle_done,
                       got.circle_done);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata  = '0;
    logic             i_s_axis_tuser  = 1'b0;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic             o_m_axis_tlast;
    logic             o_m_axis_tuser;

    t_span_board board = new();
    int        items_done   = 0;
    int        tx_idle_pct  = 6;
    int        rx_idle_pct  = 76;
    bit        hold_req     = 1'b0;
    bit        hold_taken   = 1'b0;
    int        hold_left    = 0;
    int        cycle_count  = 0;

    midpoint_circle_span_generator #(
        .COORD_BITS(CB)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("midpoint_circle_span_generator regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            board.check_span(o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
        end
    end

    task automatic send_item(input logic op, input logic [CB-1:0] cx,
                             input logic [CB-1:0] cy, input logic [CB-2:0] r);
        int n;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_W'({r, cy, cx});
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        n = board.note_input(op, cx, cy, r);
        if (n > 0) begin
            items_done++;
        end
        if (items_done >= 2*TARGET_ITEMS/3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
            hold_req    = 1'b1;
        end else if (items_done >= TARGET_ITEMS/3) begin
            tx_idle_pct = 76;
            rx_idle_pct = 6;
        end
    endtask

    task automatic send_step();
        send_item(mcsg_pkg::OP_STEP, CB'($urandom), CB'($urandom), (CB-1)'($urandom));
    endtask

    task automatic finish_circle();
        while (board.active) begin
            send_step();
        end
    endtask

    task automatic run_circle();
        int            k;
        int            n_steps;
        logic [CB-1:0] cx;
        logic [CB-1:0] cy;
        logic [CB-2:0] r;
        if ($urandom_range(9) == 0) begin
            send_step();
        end
        k = $urandom_range(99);
        if (k < 55) begin
            r = (CB-1)'($urandom_range(24, 0));
        end else if (k < 75) begin
            r = (CB-1)'($urandom_range(120, 25));
        end else if (k < 95) begin
            r = (CB-1)'($urandom);
        end else begin
            r = $urandom_range(1) ? '1 : (CB-1)'(1);
        end
        cx = CB'($urandom);
        cy = CB'($urandom);
        if ($urandom_range(7) == 0) begin
            cx = $urandom_range(1) ? '1 : '0;
        end
        if ($urandom_range(7) == 0) begin
            cy = $urandom_range(1) ? '1 : '0;
        end
        send_item(mcsg_pkg::OP_START, cx, cy, r);
        if (r > 120) begin
            n_steps = $urandom_range(12, 1);
        end else if ($urandom_range(6) == 0) begin
            n_steps = $urandom_range(int'(r) / 2);
        end else begin
            n_steps = 4096;
        end
        for (int i = 0; i < n_steps && board.active; i++) begin
            send_step();
        end
        if ($urandom_range(4) == 0) begin
            send_step();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(mcsg_pkg::OP_START, '0, '0, '0);
        send_item(mcsg_pkg::OP_STEP, '1, '1, '1);
        send_item(mcsg_pkg::OP_START, '1, '1, '0);
        send_item(mcsg_pkg::OP_START, '1, '0, (CB-1)'(1));
        finish_circle();
        send_step();
        send_item(mcsg_pkg::OP_START, '0, '1, '1);
        send_step();
        send_step();
        send_item(mcsg_pkg::OP_START, '1, '1, '1);
        send_step();
        send_item(mcsg_pkg::OP_START, CB'(2048), CB'(2048), (CB-1)'(5));
        send_step();
        send_item(mcsg_pkg::OP_START, '0, '0, '1);
        send_step();
        send_item(mcsg_pkg::OP_START, CB'('h555), CB'('haaa), (CB-1)'('h2aa));
        send_step();
        send_item(mcsg_pkg::OP_START, CB'(100), CB'(200), (CB-1)'(3));
        finish_circle();

        while (items_done < TARGET_ITEMS) begin
            run_circle();
        end

        i_s_axis_tvalid <= 1'b0;
        while (board.spans_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("midpoint_circle_span_generator regression: pass");
        end else begin
            $display("midpoint_circle_span_generator regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
